// ----- rtl/bdal_pkg.sv -----
// Package for the bf16 dot-product accumulator lanes.
// Holds payload structs, lane count and fp32 helper constants. No dependencies.
package bdal_pkg;

  localparam int unsigned MaxLanes = 8;
  localparam logic [31:0] CanonNan = 32'h7FC00000;
  localparam logic [31:0] PosInf   = 32'h7F800000;
  localparam logic [15:0] Bf16Nan  = 16'h7FC0;

  typedef struct packed {
    logic [15:0] x_val;
    logic [15:0] w_lane0;
    logic [15:0] w_lane1;
    logic [15:0] w_lane2;
    logic [15:0] w_lane3;
    logic [15:0] w_lane4;
    logic [15:0] w_lane5;
    logic [15:0] w_lane6;
    logic [15:0] w_lane7;
    logic        last_k;
  } bdal_in_t;

  typedef struct packed {
    logic [15:0] y_lane0;
    logic [15:0] y_lane1;
    logic [15:0] y_lane2;
    logic [15:0] y_lane3;
    logic [15:0] y_lane4;
    logic [15:0] y_lane5;
    logic [15:0] y_lane6;
    logic [15:0] y_lane7;
  } bdal_out_t;

  // Control that travels with an item through the lane pipeline.
  typedef struct packed {
    logic go;
    logic last;
  } bdal_ctl_t;

  function automatic logic is_nan32(input logic [31:0] v);
    return v[30:0] > PosInf[30:0];
  endfunction

  function automatic logic is_inf32(input logic [31:0] v);
    return v[30:0] == PosInf[30:0];
  endfunction

  function automatic logic is_zero32(input logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

  // Round an fp32 pattern to bf16, nearest-even.
  function automatic logic [15:0] to_bf16(input logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, v} + 33'h7FFF + {32'd0, v[16]};
    if (is_nan32(v)) return Bf16Nan;
    return s[31:16];
  endfunction

endpackage

// ----- rtl/bdal_fma.sv -----
// One lane: four-stage fp32 fused multiply-add into a private accumulator.
// Depends on bdal_pkg. Stage 1 multiplies, 2 aligns, 3 adds, 4 normalizes and rounds.
module bdal_fma (
  input  logic                clk,
  input  logic                rst,
  input  bdal_pkg::bdal_ctl_t ctl,
  input  logic [15:0]         x_val,
  input  logic [15:0]         w_val,
  output logic [31:0]         acc_out
);
  import bdal_pkg::*;

  // Accumulator and its operands staged through the pipeline.
  logic [31:0] acc;

  // ---- stage 1: classify, multiply significands ----
  logic        s1_go, s1_spec;
  logic [31:0] s1_spec_val;
  logic        s1_ps, s1_pzero;
  logic [15:0] s1_prod;
  logic signed [10:0] s1_pe;

  logic [31:0] a32, b32;
  logic [7:0]  ma, mb;
  logic signed [10:0] xa, xb;
  assign a32 = {x_val, 16'd0};
  assign b32 = {w_val, 16'd0};
  always_comb begin
    ma = (a32[30:23] == 8'd0) ? {1'b0, a32[22:16]} : {1'b1, a32[22:16]};
    mb = (b32[30:23] == 8'd0) ? {1'b0, b32[22:16]} : {1'b1, b32[22:16]};
    xa = (a32[30:23] == 8'd0) ? -11'sd133 : $signed({3'd0, a32[30:23]}) - 11'sd134;
    xb = (b32[30:23] == 8'd0) ? -11'sd133 : $signed({3'd0, b32[30:23]}) - 11'sd134;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_go <= 1'b0;
    end else begin
      s1_go <= ctl.go;
    end
    s1_ps   <= a32[31] ^ b32[31];
    s1_prod <= ma * mb;
    s1_pe   <= xa + xb;
    s1_pzero <= is_zero32(a32) || is_zero32(b32);
    s1_spec <= is_nan32(a32) || is_nan32(b32) || is_inf32(a32) || is_inf32(b32);
    if (is_nan32(a32) || is_nan32(b32) ||
        ((is_inf32(a32) || is_inf32(b32)) && (is_zero32(a32) || is_zero32(b32))))
      s1_spec_val <= CanonNan;
    else
      s1_spec_val <= {a32[31] ^ b32[31], PosInf[30:0]};
  end

  // ---- stage 2: read accumulator, resolve specials, align ----
  // The accumulator is read here; the next item is held off until it is written back.
  logic        s2_go, s2_done;
  logic [31:0] s2_done_val;
  logic        s2_bs, s2_ss;
  logic [63:0] s2_big, s2_small;
  logic signed [11:0] s2_bexp;
  logic        s2_only_prod;

  logic [23:0] mc;
  logic signed [11:0] xc, pe_n, xc_n;
  logic [63:0] pm, cm, shs;
  logic [4:0]  plz, clz;
  logic        cs;
  logic signed [12:0] diff;
  logic [31:0] dval;
  logic        done;

  always_comb begin
    cs   = acc[31];
    mc   = (acc[30:23] == 8'd0) ? {1'b0, acc[22:0]} : {1'b1, acc[22:0]};
    xc   = (acc[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, acc[30:23]}) - 12'sd150;
    plz  = 5'd0;
    for (int i = 0; i < 16; i++) if (s1_prod[i]) plz = 5'(15 - i);
    clz  = 5'd0;
    for (int i = 0; i < 24; i++) if (mc[i]) clz = 5'(23 - i);
    // product normalized with top bit at 61
    pm   = {2'b00, s1_prod, 46'd0} << plz;
    pe_n = 12'(s1_pe) - 12'sd46 - 12'(plz);
    cm   = {2'b00, mc, 38'd0} << clz;
    xc_n = xc - 12'sd38 - 12'(clz);
    done = 1'b1;
    dval = acc;
    if (s1_spec) begin
      if (!s1_spec_val[22] && is_inf32(acc) && cs != s1_ps) dval = CanonNan;
      else if (is_nan32(acc)) dval = CanonNan;
      else dval = s1_spec_val;
    end else if (is_nan32(acc)) begin
      dval = CanonNan;
    end else if (is_inf32(acc)) begin
      dval = acc;
    end else if (s1_pzero) begin
      dval = is_zero32(acc) ? {s1_ps & cs, 31'd0} : acc;
    end else begin
      done = 1'b0;
    end
    diff = 13'(pe_n) - 13'(xc_n);
    shs  = 64'd0;
  end

  function automatic logic [63:0] shr_st(input logic [63:0] v, input logic [12:0] d);
    logic [63:0] m;
    m = 64'd0;
    if (d >= 13'd63) return {63'd0, v != 64'd0};
    m = ~(64'hFFFF_FFFF_FFFF_FFFF << d[5:0]);
    return (v >> d[5:0]) | {63'd0, (v & m) != 64'd0};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_go <= 1'b0;
    end else begin
      s2_go <= s1_go;
    end
    s2_done      <= done;
    s2_done_val  <= dval;
    s2_only_prod <= is_zero32(acc);
    if (is_zero32(acc) || !diff[12]) begin
      s2_big <= pm; s2_bs <= s1_ps; s2_bexp <= pe_n;
      s2_small <= is_zero32(acc) ? shs : shr_st(cm, diff);
      s2_ss <= cs;
    end else begin
      s2_big <= cm; s2_bs <= cs; s2_bexp <= xc_n;
      s2_small <= shr_st(pm, 13'(-diff));
      s2_ss <= s1_ps;
    end
  end

  // ---- stage 3: add or subtract ----
  logic        s3_go, s3_done, s3_sign, s3_zero;
  logic [31:0] s3_done_val;
  logic [63:0] s3_r;
  logic signed [11:0] s3_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_go <= 1'b0;
    end else begin
      s3_go <= s2_go;
    end
    s3_done     <= s2_done;
    s3_done_val <= s2_done_val;
    s3_e        <= s2_bexp;
    if (s2_bs == s2_ss || s2_only_prod) begin
      s3_r <= s2_big + s2_small; s3_sign <= s2_bs;
    end else if (s2_big >= s2_small) begin
      s3_r <= s2_big - s2_small; s3_sign <= s2_bs;
    end else begin
      s3_r <= s2_small - s2_big; s3_sign <= s2_ss;
    end
    s3_zero <= (s2_bs != s2_ss) && !s2_only_prod && (s2_big == s2_small);
  end

  // ---- stage 4: normalize, round, write accumulator ----
  logic [5:0]  tb;
  logic signed [12:0] sh;
  logic [63:0] q, rem, half;
  logic signed [12:0] eq;
  logic [31:0] rounded, fin;

  always_comb begin
    tb = 6'd0;
    for (int i = 0; i < 64; i++) if (s3_r[i]) tb = 6'(i);
    sh = 13'(tb) - 13'sd23;
    if (sh < -13'sd149 - 13'(s3_e)) sh = -13'sd149 - 13'(s3_e);
    rem = 64'd0; half = 64'd0;
    if (sh[12]) begin
      q = s3_r << 6'(-sh);
    end else if (sh >= 13'sd64) begin
      // far below the smallest subnormal: flush to a signed zero
      q = 64'd0;
    end else begin
      q   = s3_r >> sh[5:0];
      if (sh != 13'sd0) begin
        rem  = s3_r & ~(64'hFFFF_FFFF_FFFF_FFFF << sh[5:0]);
        half = 64'd1 << 6'(sh - 13'sd1);
        if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end
    end
    eq = 13'(s3_e) + sh;
    if (q[24]) begin
      q = q >> 1; eq = eq + 13'sd1;
    end
    if (q == 64'd0) rounded = {s3_sign, 31'd0};
    else if (!q[23]) rounded = {s3_sign, 8'd0, q[22:0]};
    else if (eq + 13'sd150 >= 13'sd255) rounded = {s3_sign, PosInf[30:0]};
    else rounded = {s3_sign, 8'(eq + 13'sd150), q[22:0]};
    if (s3_done) fin = s3_done_val;
    else if (s3_zero) fin = 32'd0;
    else fin = rounded;
  end

  // Write back each result; clear in the cycle the merge takes a last sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= 32'd0;
    end else if (s3_go) begin
      acc <= fin;
    end else if (ctl.last) begin
      acc <= 32'd0;
    end
  end
  assign acc_out = acc;

endmodule

// ----- rtl/bf16_dot_accumulate_lanes.sv -----
// Top level: up to eight (LANES) bf16 FMA lanes with fp32 accumulators and a bf16 merge stage.
// Depends on bdal_pkg and bdal_fma.
//
//   channel | dir | handshake     | payload
//   in      | in  | in_valid/ready| bdal_in_t
//   out     | out | out_valid/rdy | bdal_out_t
//
// Each item waits for the previous one to leave the fp32 FMA loop through
// each lane's accumulator, four stages deep; a last item's write-back is captured.
// rst clears accumulators to +0 and empties the pipeline.
// A stalled output holds in its register; the lanes keep working, and a last
// request waits while that register holds an unread result or is being loaded.
module bf16_dot_accumulate_lanes #(
  parameter int unsigned LANES = bdal_pkg::MaxLanes
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bdal_pkg::bdal_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bdal_pkg::bdal_out_t out_data
);
  import bdal_pkg::*;

  logic [2:0]  phase;     // cycles left before the lanes take the next request
  logic [3:0]  last_pipe; // last flag of the request in flight, per stage
  logic        go;
  logic        cap;
  bdal_ctl_t   ctl;
  logic [15:0] w [MaxLanes];
  logic [31:0] acc [MaxLanes];

  assign w[0] = in_data.w_lane0; assign w[1] = in_data.w_lane1;
  assign w[2] = in_data.w_lane2; assign w[3] = in_data.w_lane3;
  assign w[4] = in_data.w_lane4; assign w[5] = in_data.w_lane5;
  assign w[6] = in_data.w_lane6; assign w[7] = in_data.w_lane7;

  // Accept when the lane loop is free and a last request cannot overrun the output.
  assign in_ready = (phase == 3'd0) &&
                    !(in_data.last_k && ((out_valid && !out_ready) || cap));
  assign go = in_valid && in_ready;
  assign ctl.go = go;
  assign ctl.last = last_pipe[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 3'd0;
      last_pipe <= 4'd0;
    end else begin
      phase <= go ? 3'd3 : ((phase != 3'd0) ? phase - 3'd1 : 3'd0);
      last_pipe <= {last_pipe[2:0], go && in_data.last_k};
    end
  end

  for (genvar i = 0; i < MaxLanes; i++) begin : g_lane
    if (i < LANES) begin : g_on
      logic [31:0] a;
      bdal_fma u_fma (
        .clk(clk), .rst(rst), .ctl(ctl), .x_val(in_data.x_val),
        .w_val(w[i]), .acc_out(a)
      );
      assign acc[i] = a;
    end else begin : g_off
      assign acc[i] = 32'd0;
    end
  end

  // Capture once the last request's write-back has landed.
  assign cap = last_pipe[3];

  // Merge: round each lane to bf16 into the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cap) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cap) begin
      out_data.y_lane0 <= (LANES > 0) ? to_bf16(acc[0]) : 16'd0;
      out_data.y_lane1 <= (LANES > 1) ? to_bf16(acc[1]) : 16'd0;
      out_data.y_lane2 <= (LANES > 2) ? to_bf16(acc[2]) : 16'd0;
      out_data.y_lane3 <= (LANES > 3) ? to_bf16(acc[3]) : 16'd0;
      out_data.y_lane4 <= (LANES > 4) ? to_bf16(acc[4]) : 16'd0;
      out_data.y_lane5 <= (LANES > 5) ? to_bf16(acc[5]) : 16'd0;
      out_data.y_lane6 <= (LANES > 6) ? to_bf16(acc[6]) : 16'd0;
      out_data.y_lane7 <= (LANES > 7) ? to_bf16(acc[7]) : 16'd0;
    end
  end

endmodule

// ----- rtl/bdal_checker.sv -----
// Port-level checks for bf16_dot_accumulate_lanes, bound to the top level.
// Depends on bdal_pkg.
module bdal_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input bdal_pkg::bdal_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input bdal_pkg::bdal_out_t out_data
);
  import bdal_pkg::*;

  // A request blocks the input for the following cycle.
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("input taken twice in a row");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A non-last request taken while no result is shown raises no result of its own.
  a_none: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data.last_k && !out_valid |=> ##4 !$rose(out_valid))
    else $error("result without last request");

  // Out of reset nothing is shown.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result during reset");
endmodule

bind bf16_dot_accumulate_lanes bdal_checker u_bdal_checker (.*);
